// ===== rtl/ppm_frame_decoder_top_macros.svh =====
// Assertion helpers for the PPM frame decoder.
// Each use expects clk and arst_n in the enclosing module.
`ifndef PPM_FRAME_DECODER_TOP_MACROS_SVH
`define PPM_FRAME_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PPM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define PPM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ppm_pkg.sv =====
`timescale 1ns / 1ps

package ppm_pkg;

	localparam int CHANNELS_DEF = 8;

	localparam int PADDR_W = 5;
	localparam int DATA_W  = 32;
	localparam int TIME_W  = 32;
	localparam int WIDTH_W = 12;
	localparam int OUT_W   = 11;
	localparam int COUNT_W = 4;
	localparam int PICK_W  = 3;

	localparam logic [15:0]        SYNC_MIN_RST  = 16'd3000;
	localparam logic [WIDTH_W-1:0] PULSE_MIN_RST = 12'd800;
	localparam logic [WIDTH_W-1:0] PULSE_MAX_RST = 12'd2200;
	localparam logic [COUNT_W-1:0] MIN_CH_RST    = 4'd4;
	localparam logic [PICK_W-1:0]  THR_CH_RST    = 3'd0;
	localparam logic [PICK_W-1:0]  STR_CH_RST    = 3'd1;

	localparam logic [10:0]        CLAMP_LO = 11'd1000;
	localparam logic [10:0]        CLAMP_HI = 11'd2000;
	localparam logic signed [11:0] CENTER   = 12'sd1500;

	typedef enum logic [2:0] {
		REG_SYNC_MIN  = 3'd0,
		REG_PULSE_MIN = 3'd1,
		REG_PULSE_MAX = 3'd2,
		REG_MIN_CH    = 3'd3,
		REG_THR_CH    = 3'd4,
		REG_STR_CH    = 3'd5
	} ppm_reg_t;

	typedef struct packed {
		logic [15:0]        sync_min;
		logic [WIDTH_W-1:0] pulse_min;
		logic [WIDTH_W-1:0] pulse_max;
		logic [COUNT_W-1:0] min_channels;
		logic [PICK_W-1:0]  throttle_channel;
		logic [PICK_W-1:0]  steering_channel;
	} ppm_cfg_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] throttle;
		logic signed [OUT_W-1:0] steering;
		logic [COUNT_W-1:0]      channel_count;
	} ppm_frame_t;

	// Clamp to 1000..2000, then map to (w - 1500) * 2.
	function automatic logic signed [OUT_W-1:0] ppm_center(input logic [WIDTH_W-1:0] w);
		logic [10:0]        wc;
		logic signed [11:0] d;
		if (w < {1'b0, CLAMP_LO}) begin
			wc = CLAMP_LO;
		end else if (w > {1'b0, CLAMP_HI}) begin
			wc = CLAMP_HI;
		end else begin
			wc = w[10:0];
		end
		d = $signed({1'b0, wc}) - CENTER;
		return $signed({d[9:0], 1'b0});
	endfunction

endpackage

// ===== rtl/ppm_capture_if.sv =====
`timescale 1ns / 1ps

interface ppm_capture_if;
	import ppm_pkg::*;

	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] capture_time;

	modport source (output valid, output capture_time, input ready);
	modport sink (input valid, input capture_time, output ready);
endinterface

// ===== rtl/ppm_frame_if.sv =====
`timescale 1ns / 1ps

interface ppm_frame_if;
	import ppm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] throttle;
	logic signed [OUT_W-1:0] steering;
	logic [COUNT_W-1:0]      channel_count;

	modport source (output valid, output throttle, output steering, output channel_count,
		input ready);
	modport sink (input valid, input throttle, input steering, input channel_count,
		output ready);
endinterface

// ===== rtl/ppm_frame_decoder_top.sv =====
`timescale 1ns / 1ps

// PPM frame decoder: takes one rising-edge timestamp per capture beat, one beat per clock
// while cap.ready is high, and measures the interval from the previous capture mod 2^32.
// A gap of at least sync_min ends the frame; if at least min_channels pulses were stored,
// a frame beat with centered throttle and steering (-1000..1000) and the pulse count goes
// to the output register, or the skid register on a stall. Each capture is decoded by
// one subtract, a few compares and a slot write; the output holds up to two finished
// frames, so captures flow on while a frame waits and stop only when both are unclaimed.
// Registers sit on an APB port at byte offsets 0x00 sync_min, 0x04 pulse_min,
// 0x08 pulse_max, 0x0C min_channels, 0x10 throttle_channel, 0x14 steering_channel;
// write them only while no capture is in flight.
module ppm_frame_decoder_top #(
	parameter int CHANNELS = ppm_pkg::CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppm_pkg::PADDR_W-1:0] paddr,
	input  logic [ppm_pkg::DATA_W-1:0]  pwdata,
	output logic [ppm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	ppm_capture_if.sink                 cap,
	ppm_frame_if.source                 frame
);
	import ppm_pkg::*;

	ppm_cfg_t   cfg;
	ppm_frame_t res;
	logic       res_vld;
	logic       in_ready;

	assign pready = 1'b1;

	ppm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	ppm_core #(
		.CHANNELS(CHANNELS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cap     (cap),
		.in_ready(in_ready),
		.res_vld (res_vld),
		.res     (res)
	);

	ppm_out_skid u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_vld),
		.res     (res),
		.in_ready(in_ready),
		.frame   (frame)
	);

endmodule

// ===== rtl/ppm_cfg_regs.sv =====
`timescale 1ns / 1ps

module ppm_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppm_pkg::PADDR_W-1:0]   paddr,
	input  logic [ppm_pkg::DATA_W-1:0]    pwdata,
	output logic [ppm_pkg::DATA_W-1:0]    prdata,
	output ppm_pkg::ppm_cfg_t             cfg
);
	import ppm_pkg::*;

	ppm_cfg_t cfg_q;
	ppm_reg_t reg_sel;
	logic     wr_en;

	assign reg_sel = ppm_reg_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_min         <= SYNC_MIN_RST;
			cfg_q.pulse_min        <= PULSE_MIN_RST;
			cfg_q.pulse_max        <= PULSE_MAX_RST;
			cfg_q.min_channels     <= MIN_CH_RST;
			cfg_q.throttle_channel <= THR_CH_RST;
			cfg_q.steering_channel <= STR_CH_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SYNC_MIN:  cfg_q.sync_min         <= pwdata[15:0];
				REG_PULSE_MIN: cfg_q.pulse_min        <= pwdata[WIDTH_W-1:0];
				REG_PULSE_MAX: cfg_q.pulse_max        <= pwdata[WIDTH_W-1:0];
				REG_MIN_CH:    cfg_q.min_channels     <= pwdata[COUNT_W-1:0];
				REG_THR_CH:    cfg_q.throttle_channel <= pwdata[PICK_W-1:0];
				REG_STR_CH:    cfg_q.steering_channel <= pwdata[PICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_SYNC_MIN:  prdata = DATA_W'(cfg_q.sync_min);
			REG_PULSE_MIN: prdata = DATA_W'(cfg_q.pulse_min);
			REG_PULSE_MAX: prdata = DATA_W'(cfg_q.pulse_max);
			REG_MIN_CH:    prdata = DATA_W'(cfg_q.min_channels);
			REG_THR_CH:    prdata = DATA_W'(cfg_q.throttle_channel);
			REG_STR_CH:    prdata = DATA_W'(cfg_q.steering_channel);
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== rtl/ppm_core.sv =====
`timescale 1ns / 1ps
`include "ppm_frame_decoder_top_macros.svh"

module ppm_core #(
	parameter int CHANNELS = ppm_pkg::CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ppm_pkg::ppm_cfg_t   cfg,
	ppm_capture_if.sink         cap,
	input  logic                in_ready,
	output logic                res_vld,
	output ppm_pkg::ppm_frame_t res
);
	import ppm_pkg::*;

	localparam int SLOT_W = $clog2(CHANNELS + 1);
	localparam int IDX_W  = $clog2(CHANNELS);

	logic [TIME_W-1:0]  last_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [WIDTH_W-1:0] width_q [CHANNELS];

	logic [TIME_W-1:0]  delta;
	logic               acc;
	logic               is_sync;
	logic               in_win;
	logic               full;
	logic               wr_en;
	logic [IDX_W-1:0]   widx;
	logic [IDX_W-1:0]   thr_idx;
	logic [IDX_W-1:0]   str_idx;
	logic               thr_ok;
	logic               str_ok;
	logic [WIDTH_W-1:0] thr_w;
	logic [WIDTH_W-1:0] str_w;

	assign cap.ready = in_ready;
	assign acc       = cap.valid && in_ready;
	assign delta     = cap.capture_time - last_q;
	assign is_sync   = delta >= TIME_W'(cfg.sync_min);
	assign in_win    = (delta >= TIME_W'(cfg.pulse_min)) && (delta <= TIME_W'(cfg.pulse_max));
	assign full      = slot_q == SLOT_W'(CHANNELS);
	assign widx      = slot_q[IDX_W-1:0];
	assign wr_en     = acc && !is_sync && in_win && !full;

	assign thr_ok  = 32'(cfg.throttle_channel) < CHANNELS;
	assign str_ok  = 32'(cfg.steering_channel) < CHANNELS;
	assign thr_idx = IDX_W'(cfg.throttle_channel);
	assign str_idx = IDX_W'(cfg.steering_channel);
	assign thr_w   = thr_ok ? width_q[thr_idx] : '0;
	assign str_w   = str_ok ? width_q[str_idx] : '0;

	assign res_vld           = acc && is_sync && (32'(slot_q) >= 32'(cfg.min_channels));
	assign res.throttle      = ppm_center(thr_w);
	assign res.steering      = ppm_center(str_w);
	assign res.channel_count = COUNT_W'(slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			slot_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				width_q[i] <= '0;
			end
		end else if (acc) begin
			last_q <= cap.capture_time;
			if (is_sync) begin
				slot_q <= '0;
			end else if (wr_en) begin
				slot_q        <= slot_q + 1'b1;
				width_q[widx] <= delta[WIDTH_W-1:0];
			end
		end
	end

	`PPM_ASSERT_IMP(a_slot_bound, 1'b1, 32'(slot_q) <= CHANNELS, "slot index past channel count")
	`PPM_ASSERT_NXT(a_sync_clears, acc && is_sync, slot_q == '0, "sync gap did not clear slot")
	`PPM_ASSERT_NXT(a_pulse_adv, wr_en, 32'(slot_q) == 32'($past(slot_q)) + 1, "pulse did not advance slot")

endmodule

// ===== rtl/ppm_out_skid.sv =====
`timescale 1ns / 1ps
`include "ppm_frame_decoder_top_macros.svh"

module ppm_out_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ppm_pkg::ppm_frame_t res,
	output logic                in_ready,
	ppm_frame_if.source         frame
);
	import ppm_pkg::*;

	logic       out_vld_q;
	logic       skid_vld_q;
	ppm_frame_t out_q;
	ppm_frame_t skid_q;
	logic       out_free;

	assign in_ready            = !skid_vld_q;
	assign out_free            = frame.ready || !out_vld_q;
	assign frame.valid         = out_vld_q;
	assign frame.throttle      = out_q.throttle;
	assign frame.steering      = out_q.steering;
	assign frame.channel_count = out_q.channel_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	`PPM_ASSERT_IMP(a_skid_behind_out, skid_vld_q, out_vld_q, "skid beat held with output empty")

endmodule

// ===== sim/tb_ppm_frame_decoder_top.sv =====
`timescale 1ns / 1ps

import ppm_pkg::*;

class ppm_frame_board;
	ppm_cfg_t           cfg;
	logic [TIME_W-1:0]  prev_stamp;
	logic [COUNT_W-1:0] filled;
	logic [WIDTH_W-1:0] widths [CHANNELS_DEF];
	ppm_frame_t         frames_due[$];
	int                 errors;

	function new();
		cfg.sync_min         = SYNC_MIN_RST;
		cfg.pulse_min        = PULSE_MIN_RST;
		cfg.pulse_max        = PULSE_MAX_RST;
		cfg.min_channels     = MIN_CH_RST;
		cfg.throttle_channel = THR_CH_RST;
		cfg.steering_channel = STR_CH_RST;
		prev_stamp = '0;
		filled     = '0;
		foreach (widths[i]) widths[i] = '0;
		errors = 0;
	endfunction

	function void set_reg(ppm_reg_t idx, logic [DATA_W-1:0] value);
		case (idx)
			REG_SYNC_MIN:  cfg.sync_min = value[15:0];
			REG_PULSE_MIN: cfg.pulse_min = value[WIDTH_W-1:0];
			REG_PULSE_MAX: cfg.pulse_max = value[WIDTH_W-1:0];
			REG_MIN_CH:    cfg.min_channels = value[COUNT_W-1:0];
			REG_THR_CH:    cfg.throttle_channel = value[PICK_W-1:0];
			REG_STR_CH:    cfg.steering_channel = value[PICK_W-1:0];
			default: begin
			end
		endcase
	endfunction

	function logic signed [OUT_W-1:0] centered(logic [PICK_W-1:0] pick);
		logic [WIDTH_W-1:0] w;
		int                 v;
		w = '0;
		if (int'(pick) < CHANNELS_DEF) w = widths[pick];
		if (w < 12'd1000) w = 12'd1000;
		else if (w > 12'd2000) w = 12'd2000;
		v = (int'(w) - 1500) * 2;
		return OUT_W'(v);
	endfunction

	function void capture_beat(logic [TIME_W-1:0] stamp);
		logic [TIME_W-1:0] gap;
		ppm_frame_t        f;
		gap = stamp - prev_stamp;
		prev_stamp = stamp;
		if (gap >= {16'd0, cfg.sync_min}) begin
			if (filled >= cfg.min_channels) begin
				f.throttle      = centered(cfg.throttle_channel);
				f.steering      = centered(cfg.steering_channel);
				f.channel_count = filled;
				frames_due.push_back(f);
			end
			filled = '0;
		end else if (gap >= {20'd0, cfg.pulse_min} && gap <= {20'd0, cfg.pulse_max}) begin
			if (int'(filled) < CHANNELS_DEF) begin
				widths[filled] = gap[WIDTH_W-1:0];
				filled = filled + 1'b1;
			end
		end
	endfunction

	task report_miss(string what);
		errors++;
		if (errors <= 100) $display("frame mismatch: %s", what);
	endtask

	task frame_beat(ppm_frame_t got);
		ppm_frame_t want;
		if (frames_due.size() == 0) begin
			report_miss($sformatf("unexpected beat thr=%0d str=%0d cnt=%0d",
				got.throttle, got.steering, got.channel_count));
			return;
		end
		want = frames_due.pop_front();
		if (got.throttle !== want.throttle)
			report_miss($sformatf("throttle %0d, want %0d", got.throttle, want.throttle));
		if (got.steering !== want.steering)
			report_miss($sformatf("steering %0d, want %0d", got.steering, want.steering));
		if (got.channel_count !== want.channel_count)
			report_miss($sformatf("channel_count %0d, want %0d", got.channel_count,
				want.channel_count));
	endtask
endclass

module tb_ppm_frame_decoder_top;
	localparam int STUCK_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	ppm_capture_if cap_bus ();
	ppm_frame_if   frame_bus ();

	ppm_frame_board    board;
	logic [TIME_W-1:0] now_us;
	bit                calm;
	int                hold_ask;
	int                stuck;

	ppm_frame_decoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap     (cap_bus),
		.frame   (frame_bus)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		ppm_frame_t got;
		if (cap_bus.valid && cap_bus.ready) board.capture_beat(cap_bus.capture_time);
		if (frame_bus.valid && frame_bus.ready) begin
			got.throttle      = frame_bus.throttle;
			got.steering      = frame_bus.steering;
			got.channel_count = frame_bus.channel_count;
			board.frame_beat(got);
		end
		if ((cap_bus.valid && cap_bus.ready) || (frame_bus.valid && frame_bus.ready) ||
			(psel && penable)) begin
			stuck = 0;
		end else begin
			stuck++;
		end
		if (stuck >= STUCK_LIMIT) begin
			$display("tb_ppm_frame_decoder_top: errors");
			$finish;
		end
	end

	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		frame_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask > 0) begin
				hold_left = hold_ask;
				hold_ask  = 0;
			end
			if (hold_left > 0) begin
				frame_bus.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				frame_bus.ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				frame_bus.ready <= 1'b0;
				stall_left = $urandom_range(0, 18);
			end else begin
				frame_bus.ready <= 1'b1;
			end
		end
	end

	task automatic reg_write(ppm_reg_t idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_reg(idx, value);
	endtask

	task automatic push_capture(logic [TIME_W-1:0] gap);
		now_us = now_us + gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			cap_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		cap_bus.valid        <= 1'b1;
		cap_bus.capture_time <= now_us;
		@(posedge clk);
		while (!cap_bus.ready) @(posedge clk);
	endtask

	task automatic drain();
		cap_bus.valid <= 1'b0;
		do @(posedge clk); while (board.frames_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(int sync, int pmin, int pmax, int minch, int thr, int str);
		drain();
		reg_write(REG_SYNC_MIN, sync);
		reg_write(REG_PULSE_MIN, pmin);
		reg_write(REG_PULSE_MAX, pmax);
		reg_write(REG_MIN_CH, minch);
		reg_write(REG_THR_CH, thr);
		reg_write(REG_STR_CH, str);
	endtask

	function automatic logic [TIME_W-1:0] noise_gap();
		if ($urandom_range(0, 3) == 0) return $urandom();
		return $urandom_range(0, 6000);
	endfunction

	function automatic logic [TIME_W-1:0] pulse_gap();
		if (board.cfg.pulse_min > board.cfg.pulse_max) return noise_gap();
		return $urandom_range(board.cfg.pulse_min, board.cfg.pulse_max);
	endfunction

	function automatic logic [TIME_W-1:0] sync_gap();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return $urandom();
		if (pick == 1) return board.cfg.sync_min;
		return board.cfg.sync_min + $urandom_range(0, 4000);
	endfunction

	task automatic random_frames(int count);
		int done;
		int k;
		int floor_ch;
		done = 0;
		while (done < count) begin
			floor_ch = (board.cfg.min_channels > 9) ? 9 : board.cfg.min_channels;
			k = ($urandom_range(0, 9) < 7) ? $urandom_range(floor_ch, 9) : $urandom_range(0, 9);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(0, 11) == 0) begin
					push_capture(noise_gap());
					done++;
				end
				push_capture(pulse_gap());
				done++;
			end
			push_capture(sync_gap());
			done++;
		end
	endtask

	initial begin
		board    = new();
		calm     = 1'b0;
		hold_ask = 0;
		stuck    = 0;
		now_us   = '0;
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		cap_bus.valid        <= 1'b0;
		cap_bus.capture_time <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_capture(2200);
		push_capture(800);
		push_capture(1000);
		push_capture(799);
		push_capture(2201);
		push_capture(1500);
		push_capture(2999);
		push_capture(3000);
		for (int i = 0; i < 9; i++) push_capture(2000 - i * 50);
		push_capture(32'hFFFF_FFFF);
		push_capture(1200);
		push_capture(1300);
		push_capture(1400);
		push_capture(5000);

		set_config(3000, 800, 2200, 8, 7, 6);
		random_frames(200);

		set_config(0, 800, 2200, 0, 7, 0);
		hold_ask = HOLD_CYCLES;
		random_frames(60);
		drain();
		random_frames(90);

		set_config(65535, 0, 4095, 1, 3, 5);
		random_frames(200);

		set_config(4000, 3000, 100, 0, 2, 4);
		random_frames(100);

		set_config(3000, 800, 2200, 9, 0, 1);
		random_frames(50);

		set_config(3000, 800, 2200, 15, 0, 1);
		random_frames(50);

		for (int p = 0; p < 4; p++) begin
			set_config($urandom_range(2300, 8000), $urandom_range(0, 1200),
				$urandom_range(1600, 4095), $urandom_range(0, 8), $urandom_range(0, 7),
				$urandom_range(0, 7));
			random_frames(150);
		end

		set_config(3000, 800, 2200, 4, 0, 1);
		calm = 1'b1;
		random_frames(300);

		drain();
		repeat (6) @(posedge clk);
		if (board.errors == 0) begin
			$display("tb_ppm_frame_decoder_top: clean");
		end else begin
			$display("tb_ppm_frame_decoder_top: errors");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ppm_pkg.sv
rtl/ppm_capture_if.sv
rtl/ppm_frame_if.sv
rtl/ppm_cfg_regs.sv
rtl/ppm_core.sv
rtl/ppm_out_skid.sv
rtl/ppm_frame_decoder_top.sv
sim/tb_ppm_frame_decoder_top.sv
